// ----- sv/srpm_pkg.sv -----
package srpm_pkg;

  localparam int WRITE_BITS_DEF  = 32;
  localparam int SELECT_BITS_DEF = 9;
  localparam int READ_BITS_DEF   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int WORD_W     = 32;
  localparam int RWORD_W    = 16;

  localparam logic [CFG_DATA_W-1:0] HALF_BIT_RST    = 16'd1;
  localparam logic [CFG_DATA_W-1:0] LATCH_PULSE_RST = 16'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH_PULSE = 2'd1;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_ENABLE = 2'd3
  } srpm_kind_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] half_bit_ticks;
    logic [CFG_DATA_W-1:0] latch_pulse_ticks;
  } srpm_cfg_t;

  typedef struct packed {
    logic               sclk_level;
    logic               sdata_level;
    logic               latch_level;
    logic               enable_level;
    logic               busy_res;
    logic [RWORD_W-1:0] read_word;
    logic               read_done;
    logic               rejected;
  } srpm_res_t;

endpackage

// ----- sv/serial_register_port_master.sv -----
// Channel  Direction  Handshake                  Payload
// in       input      in_valid_i / in_ready_o    kind_i, value_i, sread_i
// out      output     out_valid_o / out_ready_i  pin levels, busy, read word, flags
// cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained; each item is one tick of the serial port.
// An item is first held in the input register, then the sequencer step
// loads the result register from it, and that makes the result valid.
// Only out_ready_i low slows the block; the input register keeps accepting
// until it holds an item waiting on a full result register.
// Reset clears the sequencer, the pins and the valid flags at once; the input payload registers are not reset.
module serial_register_port_master
  import srpm_pkg::*;
#(
  parameter int WRITE_BITS  = WRITE_BITS_DEF,
  parameter int SELECT_BITS = SELECT_BITS_DEF,
  parameter int READ_BITS   = READ_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            kind_i,
  input  logic [WORD_W-1:0]     value_i,
  input  logic                  sread_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  sclk_level_o,
  output logic                  sdata_level_o,
  output logic                  latch_level_o,
  output logic                  enable_level_o,
  output logic                  busy_res_o,
  output logic [RWORD_W-1:0]    read_word_o,
  output logic                  read_done_o,
  output logic                  rejected_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic              in_valid_q, in_valid_d;
  srpm_kind_e        kind_q;
  logic [WORD_W-1:0] value_q;
  logic              sread_q;
  logic              out_valid_q, out_valid_d;
  logic              step;
  logic              in_fire;
  srpm_cfg_t         cfg;
  srpm_res_t         res;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= srpm_kind_e'(kind_i);
      value_q <= value_i;
      sread_q <= sread_i;
    end
  end

  srpm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  srpm_core #(
    .WRITE_BITS  (WRITE_BITS),
    .SELECT_BITS (SELECT_BITS),
    .READ_BITS   (READ_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .kind_i  (kind_q),
    .value_i (value_q),
    .sread_i (sread_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign out_valid_o    = out_valid_q;
  assign sclk_level_o   = res.sclk_level;
  assign sdata_level_o  = res.sdata_level;
  assign latch_level_o  = res.latch_level;
  assign enable_level_o = res.enable_level;
  assign busy_res_o     = res.busy_res;
  assign read_word_o    = res.read_word;
  assign read_done_o    = res.read_done;
  assign rejected_o     = res.rejected;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_done_o |-> !busy_res_o)
    else $error("readback done while still busy");

  a_idle_clk_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> !sclk_level_o && !latch_level_o)
    else $error("serial clock or latch high while idle");

  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q && !($past(in_fire) == 1'b0 && in_valid_q && $past(!in_valid_q)))
    else $error("result register not loaded after step");
`endif

endmodule

// ----- sv/srpm_cfg.sv -----
module srpm_cfg
  import srpm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output srpm_cfg_t             cfg_o
);

  logic [CFG_DATA_W-1:0] half_q, half_d;
  logic [CFG_DATA_W-1:0] latch_q, latch_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    half_d  = half_q;
    latch_d = latch_q;
    if (cfg_valid_i && cfg_ready_o) begin
      priority if (cfg_index_i == CFG_HALF_BIT) begin
        half_d = cfg_data_i;
      end else if (cfg_index_i == CFG_LATCH_PULSE) begin
        latch_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HALF_BIT_RST;
      latch_q <= LATCH_PULSE_RST;
    end else begin
      half_q  <= half_d;
      latch_q <= latch_d;
    end
  end

  assign cfg_o.half_bit_ticks    = half_q;
  assign cfg_o.latch_pulse_ticks = latch_q;

endmodule

// ----- sv/srpm_core.sv -----
module srpm_core
  import srpm_pkg::*;
#(
  parameter int WRITE_BITS  = WRITE_BITS_DEF,
  parameter int SELECT_BITS = SELECT_BITS_DEF,
  parameter int READ_BITS   = READ_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  srpm_kind_e        kind_i,
  input  logic [WORD_W-1:0] value_i,
  input  logic              sread_i,
  input  srpm_cfg_t         cfg_i,
  output srpm_res_t         res_o
);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_W_LOW   = 4'd1,
    PH_W_HIGH  = 4'd2,
    PH_W_TAIL  = 4'd3,
    PH_W_LATCH = 4'd4,
    PH_S_LOW   = 4'd5,
    PH_S_HIGH  = 4'd6,
    PH_S_TAIL  = 4'd7,
    PH_R_SETUP = 4'd8,
    PH_R_LOW   = 4'd9,
    PH_R_HIGH  = 4'd10,
    PH_R_TAIL  = 4'd11
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [5:0]            bits_q, bits_d;
  logic [WORD_W-1:0]     out_q, out_d;
  logic [READ_BITS-1:0]  in_q, in_d;
  logic [CFG_DATA_W-1:0] wait_q, wait_d;
  logic                  sclk_q, sclk_d;
  logic                  sdata_q, sdata_d;
  logic                  latch_q, latch_d;
  logic                  en_q, en_d;
  logic [RWORD_W-1:0]    last_q, last_d;
  logic                  done_q, done_d;
  logic                  rej_q, rej_d;

  logic [5:0]            bits_dec;
  logic [4:0]            idx;
  logic [CFG_DATA_W-1:0] half_m1;
  logic [CFG_DATA_W-1:0] latch_m1;
  logic [READ_BITS-1:0]  in_smp;

  always_comb begin
    phase_d  = phase_q;
    bits_d   = bits_q;
    out_d    = out_q;
    in_d     = in_q;
    wait_d   = wait_q;
    sclk_d   = sclk_q;
    sdata_d  = sdata_q;
    latch_d  = latch_q;
    en_d     = en_q;
    last_d   = last_q;
    done_d   = 1'b0;
    rej_d    = 1'b0;
    bits_dec = bits_q - 6'd1;
    idx      = bits_dec[4:0] - 5'd1;
    half_m1  = (cfg_i.half_bit_ticks == '0) ? '0 : cfg_i.half_bit_ticks - 16'd1;
    latch_m1 = (cfg_i.latch_pulse_ticks == '0) ? '0 : cfg_i.latch_pulse_ticks - 16'd1;
    in_smp   = (in_q << 1) | READ_BITS'(sread_i);

    if (phase_q != PH_IDLE) begin
      rej_d = (kind_i != KIND_TICK);
      if (wait_q != '0) begin
        wait_d = wait_q - 16'd1;
      end else begin
        unique case (phase_q)
          PH_W_LOW, PH_S_LOW: begin
            sclk_d  = 1'b1;
            phase_d = (phase_q == PH_W_LOW) ? PH_W_HIGH : PH_S_HIGH;
            wait_d  = half_m1;
          end
          PH_W_HIGH, PH_S_HIGH: begin
            bits_d = bits_dec;
            sclk_d = 1'b0;
            wait_d = half_m1;
            if (bits_dec != '0) begin
              sdata_d = out_q[idx];
              phase_d = (phase_q == PH_W_HIGH) ? PH_W_LOW : PH_S_LOW;
            end else begin
              phase_d = (phase_q == PH_W_HIGH) ? PH_W_TAIL : PH_S_TAIL;
            end
          end
          PH_W_TAIL: begin
            latch_d = 1'b1;
            phase_d = PH_W_LATCH;
            wait_d  = latch_m1;
          end
          PH_S_TAIL: begin
            latch_d = 1'b1;
            phase_d = PH_R_SETUP;
            wait_d  = half_m1;
          end
          PH_R_SETUP: begin
            bits_d  = 6'(READ_BITS);
            sclk_d  = 1'b0;
            in_d    = in_smp;
            phase_d = PH_R_LOW;
            wait_d  = half_m1;
          end
          PH_R_LOW: begin
            sclk_d  = 1'b1;
            phase_d = PH_R_HIGH;
            wait_d  = half_m1;
          end
          PH_R_HIGH: begin
            bits_d = bits_dec;
            sclk_d = 1'b0;
            wait_d = half_m1;
            if (bits_dec != '0) begin
              in_d    = in_smp;
              phase_d = PH_R_LOW;
            end else begin
              phase_d = PH_R_TAIL;
            end
          end
          PH_R_TAIL: begin
            latch_d = 1'b0;
            last_d  = RWORD_W'(in_q);
            done_d  = 1'b1;
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
          default: begin
            latch_d = 1'b0;
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        endcase
      end
    end else begin
      unique case (kind_i)
        KIND_WRITE: begin
          out_d   = value_i;
          bits_d  = 6'(WRITE_BITS);
          latch_d = 1'b0;
          sclk_d  = 1'b0;
          sdata_d = value_i[WRITE_BITS-1];
          phase_d = PH_W_LOW;
          wait_d  = half_m1;
        end
        KIND_READ: begin
          out_d   = WORD_W'(value_i[SELECT_BITS-1:0]);
          bits_d  = 6'(SELECT_BITS);
          in_d    = '0;
          latch_d = 1'b0;
          sclk_d  = 1'b0;
          sdata_d = value_i[SELECT_BITS-1];
          phase_d = PH_S_LOW;
          wait_d  = half_m1;
        end
        KIND_ENABLE: begin
          en_d = value_i[0];
        end
        default: begin
          en_d = en_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bits_q  <= '0;
      out_q   <= '0;
      in_q    <= '0;
      wait_q  <= '0;
      sclk_q  <= 1'b0;
      sdata_q <= 1'b0;
      latch_q <= 1'b0;
      en_q    <= 1'b0;
      last_q  <= '0;
      done_q  <= 1'b0;
      rej_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      out_q   <= out_d;
      in_q    <= in_d;
      wait_q  <= wait_d;
      sclk_q  <= sclk_d;
      sdata_q <= sdata_d;
      latch_q <= latch_d;
      en_q    <= en_d;
      last_q  <= last_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
    end
  end

  assign res_o.sclk_level   = sclk_q;
  assign res_o.sdata_level  = sdata_q;
  assign res_o.latch_level  = latch_q;
  assign res_o.enable_level = en_q;
  assign res_o.busy_res     = (phase_q != PH_IDLE);
  assign res_o.read_word    = last_q;
  assign res_o.read_done    = done_q;
  assign res_o.rejected     = rej_q;

endmodule
